// File: rtl/core/packet_mailbox_command_engine_macros.svh
// Assertion macros used by the packet mailbox command engine top level.
`ifndef PACKET_MAILBOX_COMMAND_ENGINE_MACROS_SVH
`define PACKET_MAILBOX_COMMAND_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PMCE_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PMCE_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pmce_pkg.sv
// Shared constants, codes and interface types of the packet mailbox command engine.
package pmce_pkg;

  localparam int BANK_BYTES   = 18;
  localparam int PACKET_BYTES = 20;
  localparam int RAM_DEPTH    = 2 * BANK_BYTES;
  localparam int BANK_AW      = $clog2(RAM_DEPTH);
  localparam int IDX_W        = $clog2(BANK_BYTES);
  localparam int LEN_W        = $clog2(BANK_BYTES + 1);
  localparam int POS_W        = $clog2(PACKET_BYTES + 1);

  localparam logic [7:0] CMD_WRITE0 = 8'd4;
  localparam logic [7:0] CMD_READ0  = 8'd5;
  localparam logic [7:0] CMD_INC0   = 8'd6;
  localparam logic [7:0] CMD_WRITE1 = 8'd7;
  localparam logic [7:0] CMD_READ1  = 8'd8;
  localparam logic [7:0] CMD_INC1   = 8'd9;

  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         wdata;
  } ram_req_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       last;
  } tx_load_t;

endpackage

// File: rtl/core/packet_mailbox_command_engine.sv
// Top level of the packet mailbox command engine: sequencer, bank RAM and output register.
//
// The slave stream carries one received packet byte per transaction: the
// command byte, a length byte, then data; tlast marks the final byte of the
// packet. Input bytes are taken one per cycle while a packet is being received.
// When the last byte is accepted, the command runs against one of the two
// mailbox banks held in a single-port RAM and the input side stalls until the
// response has been handed to the output register.
// Execution decodes the command in S_EXEC, then clears up to 18 unused bytes of a
// Write in S_FILL, or runs the read-modify-write of an Increment over the low
// four bytes of the bank in S_INC_RD and S_INC_WR. Each response byte is then
// read from the RAM in S_EMIT_RD, then loaded into the output register in
// S_EMIT_LD, once the register is free.
// The master stream presents each response byte from a register; tlast marks
// the last byte. If the receiver stalls, the byte holds and the sequencer waits
// before reading the next one. Once the last byte sits in the register, a new
// packet may already be received.
// Reset clears all control state, the bank lengths and written flags; the bank
// RAM needs no clearing because a bank is only read after a Write filled it.
module packet_mailbox_command_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte [7:0]
  input  logic       s_tlast,   // rx_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // tx_byte [7:0]
  output logic       m_tlast    // tx_last
);

`include "packet_mailbox_command_engine_macros.svh"

  pmce_pkg::tx_load_t tx;
  pmce_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;
  logic               out_free;
  logic               rx_last_in;

  // The output register is free in the next cycle if it is empty or being taken now.
  assign out_free = !m_tvalid || m_tready;

  pmce_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .out_free  (out_free),
    .tx        (tx),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  pmce_bank_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Output register: loaded by the sequencer, emptied by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tx.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tx.load) begin
      m_tdata <= tx.data;
      m_tlast <= tx.last;
    end
  end

  // The final byte of a packet is taken in this transaction.
  assign rx_last_in = s_tvalid && s_tready && s_tlast;

  // A response byte is only loaded into an empty output register.
  `PMCE_ASSERT_NOW(a_load_empty, clk, rst, tx.load, !m_tvalid, "load into a full output register")
  // No input is taken while the response is being produced.
  `PMCE_ASSERT_NOW(a_no_rx_in_emit, clk, rst, tx.load, !s_tready, "input open while emitting")
  // The end of a packet stops the input side for command execution.
  `PMCE_ASSERT_NEXT(a_end_stalls, clk, rst, rx_last_in, !s_tready, "input open after packet end")
  // The RAM is never written while a response byte is loaded.
  `PMCE_ASSERT_NOW(a_no_write_on_load, clk, rst, tx.load, !ram_req.we, "RAM write during load")

endmodule

// File: rtl/core/pmce_bank_ram.sv
// Mailbox bank storage: one synchronous single-port RAM holding both banks.
module pmce_bank_ram (
  input  logic                clk,
  input  pmce_pkg::ram_req_t  req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [pmce_pkg::RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// File: rtl/core/pmce_seq.sv
// Packet collection and command sequencer working on the mailbox bank RAM.
module pmce_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,
  input  logic                                s_tlast,
  input  logic                                out_free,
  output pmce_pkg::tx_load_t                  tx,
  output pmce_pkg::ram_req_t                  ram_req,
  input  logic [7:0]                          ram_rdata
);

  typedef enum logic [2:0] {
    S_RX, S_EXEC, S_FILL, S_INC_RD, S_INC_WR, S_EMIT_RD, S_EMIT_LD
  } state_t;

  typedef enum logic [1:0] {K_WRITE, K_READ, K_INC, K_OTHER} kind_t;

  function automatic kind_t cmd_kind(input logic [7:0] c);
    kind_t k;
    k = K_OTHER;
    if (c == pmce_pkg::CMD_WRITE0 || c == pmce_pkg::CMD_WRITE1) k = K_WRITE;
    if (c == pmce_pkg::CMD_READ0 || c == pmce_pkg::CMD_READ1) k = K_READ;
    if (c == pmce_pkg::CMD_INC0 || c == pmce_pkg::CMD_INC1) k = K_INC;
    return k;
  endfunction

  function automatic logic [pmce_pkg::BANK_AW-1:0] bank_addr(
    input logic b, input logic [pmce_pkg::IDX_W-1:0] idx);
    logic [pmce_pkg::BANK_AW-1:0] base;
    base = b ? pmce_pkg::BANK_AW'(pmce_pkg::BANK_BYTES) : '0;
    return base + pmce_pkg::BANK_AW'(idx);
  endfunction

  state_t                       state;
  logic [pmce_pkg::POS_W-1:0]   pos;
  logic [7:0]                   cmd;
  logic [7:0]                   len;
  logic                         bank;
  logic                         zero_mode;
  logic                         carry;
  logic [pmce_pkg::LEN_W-1:0]   cnt;
  logic [pmce_pkg::LEN_W-1:0]   resp_len;
  logic [pmce_pkg::LEN_W-1:0]   blen [2];
  logic [1:0]                   written;

  logic                         accept;
  logic                         cmd_bank;
  kind_t                        kind;
  logic [pmce_pkg::POS_W-1:0]   data_pos;
  logic [pmce_pkg::LEN_W-1:0]   data_cnt;
  logic [pmce_pkg::LEN_W-1:0]   len_clamp;
  logic                         rx_store;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_RX);
  assign kind     = cmd_kind(cmd);
  assign cmd_bank = (cmd >= pmce_pkg::CMD_WRITE1);
  assign data_pos = pos - pmce_pkg::POS_W'(2);

  // Data bytes go straight into the target bank while a Write packet arrives.
  assign rx_store = accept && (pos < pmce_pkg::POS_W'(pmce_pkg::PACKET_BYTES)) &&
                    (pos >= pmce_pkg::POS_W'(2)) && (kind == K_WRITE) &&
                    (data_pos < pmce_pkg::POS_W'(pmce_pkg::BANK_BYTES));

  always_comb begin
    if (pos <= pmce_pkg::POS_W'(2)) begin
      data_cnt = '0;
    end else if (data_pos >= pmce_pkg::POS_W'(pmce_pkg::BANK_BYTES)) begin
      data_cnt = pmce_pkg::LEN_W'(pmce_pkg::BANK_BYTES);
    end else begin
      data_cnt = pmce_pkg::LEN_W'(data_pos);
    end
    if (len > 8'(pmce_pkg::BANK_BYTES)) begin
      len_clamp = pmce_pkg::LEN_W'(pmce_pkg::BANK_BYTES);
    end else begin
      len_clamp = pmce_pkg::LEN_W'(len);
    end
  end

  always_comb begin
    ram_req = '0;
    unique case (state)
      S_RX: begin
        ram_req.we    = rx_store;
        ram_req.addr  = bank_addr(cmd_bank, pmce_pkg::IDX_W'(data_pos));
        ram_req.wdata = s_tdata;
      end
      S_FILL: begin
        ram_req.we   = 1'b1;
        ram_req.addr = bank_addr(bank, cnt[pmce_pkg::IDX_W-1:0]);
      end
      S_INC_WR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = bank_addr(bank, cnt[pmce_pkg::IDX_W-1:0]);
        ram_req.wdata = ram_rdata + {7'd0, carry};
      end
      S_INC_RD, S_EMIT_RD, S_EXEC, S_EMIT_LD: begin
        ram_req.addr = bank_addr(bank, cnt[pmce_pkg::IDX_W-1:0]);
      end
      default: ram_req = '0;
    endcase
  end

  always_comb begin
    tx.load = (state == S_EMIT_LD);
    tx.data = zero_mode ? 8'd0 : ram_rdata;
    tx.last = (cnt + pmce_pkg::LEN_W'(1) == resp_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RX;
      pos       <= '0;
      cmd       <= '0;
      len       <= '0;
      bank      <= 1'b0;
      zero_mode <= 1'b1;
      carry     <= 1'b0;
      cnt       <= '0;
      resp_len  <= '0;
      blen[0]   <= '0;
      blen[1]   <= '0;
      written   <= '0;
    end else begin
      unique case (state)
        S_RX: begin
          if (accept) begin
            if (pos < pmce_pkg::POS_W'(pmce_pkg::PACKET_BYTES)) begin
              pos <= pos + pmce_pkg::POS_W'(1);
              if (pos == '0) begin
                cmd <= s_tdata;
                len <= 8'd0;
              end else if (pos == pmce_pkg::POS_W'(1)) begin
                len <= s_tdata;
              end
            end
            if (s_tlast) begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          pos  <= '0;
          bank <= cmd_bank;
          unique case (kind)
            K_WRITE: begin
              blen[cmd_bank]    <= len_clamp;
              written[cmd_bank] <= 1'b1;
              zero_mode         <= 1'b1;
              if (data_cnt < pmce_pkg::LEN_W'(pmce_pkg::BANK_BYTES)) begin
                cnt   <= data_cnt;
                state <= S_FILL;
              end else begin
                cnt   <= '0;
                state <= S_EMIT_RD;
              end
            end
            K_READ: begin
              cnt   <= '0;
              state <= S_EMIT_RD;
              if (written[cmd_bank] && (len <= 8'(blen[cmd_bank]))) begin
                resp_len  <= pmce_pkg::LEN_W'(len);
                zero_mode <= 1'b0;
              end else begin
                resp_len  <= pmce_pkg::LEN_W'(1);
                zero_mode <= 1'b1;
              end
            end
            K_INC: begin
              cnt <= '0;
              if (written[cmd_bank]) begin
                resp_len  <= blen[cmd_bank];
                zero_mode <= 1'b0;
                carry     <= 1'b1;
                state     <= S_INC_RD;
              end else begin
                resp_len  <= pmce_pkg::LEN_W'(1);
                zero_mode <= 1'b1;
                state     <= S_EMIT_RD;
              end
            end
            K_OTHER: begin
              cnt       <= '0;
              zero_mode <= 1'b1;
              state     <= S_EMIT_RD;
            end
            default: begin
              cnt   <= '0;
              state <= S_EMIT_RD;
            end
          endcase
        end
        S_FILL: begin
          // Bank bytes past the received data are cleared one per cycle.
          if (cnt == pmce_pkg::LEN_W'(pmce_pkg::BANK_BYTES - 1)) begin
            cnt   <= '0;
            state <= S_EMIT_RD;
          end else begin
            cnt <= cnt + pmce_pkg::LEN_W'(1);
          end
        end
        S_INC_RD: begin
          state <= S_INC_WR;
        end
        S_INC_WR: begin
          carry <= carry && (ram_rdata == 8'hFF);
          if (cnt == pmce_pkg::LEN_W'(3)) begin
            cnt   <= '0;
            state <= S_EMIT_RD;
          end else begin
            cnt   <= cnt + pmce_pkg::LEN_W'(1);
            state <= S_INC_RD;
          end
        end
        S_EMIT_RD: begin
          if (cnt == resp_len) begin
            state <= S_RX;
          end else if (out_free) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          cnt <= cnt + pmce_pkg::LEN_W'(1);
          if (tx.last) begin
            state <= S_RX;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        default: state <= S_RX;
      endcase
    end
  end

endmodule

// File: tb/packet_mailbox_command_engine_checker.sv
// Response checker for the packet mailbox command engine: mailbox prediction and byte compare.
module packet_mailbox_command_engine_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte [7:0]
  input  logic       s_tlast,   // rx_end
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // tx_byte [7:0]
  input  logic       m_tlast,   // tx_last
  output int         mismatch_count,
  output int         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  reply_beat_t                expected_tx [$];
  logic [7:0]                 packet_buf [pmce_pkg::PACKET_BYTES];
  logic [7:0]                 mailbox [pmce_pkg::RAM_DEPTH];
  logic [pmce_pkg::LEN_W-1:0] mailbox_len [2];
  logic                       mailbox_full [2];
  logic [pmce_pkg::LEN_W-1:0] reply_len;
  logic [pmce_pkg::POS_W-1:0] rx_count;

  // Runs the command of a finished packet and queues the response bytes it produces.
  function automatic void execute_packet();
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [7:0]  reply [pmce_pkg::BANK_BYTES];
    logic [31:0] word;
    int          bidx;
    int          base;
    int          n;
    reply_beat_t beat;
    cmd = packet_buf[0];
    len = packet_buf[1];
    for (int i = 0; i < pmce_pkg::BANK_BYTES; i++) reply[i] = 8'h00;
    if (cmd >= pmce_pkg::CMD_WRITE0 && cmd <= pmce_pkg::CMD_INC1) begin
      bidx = (cmd >= pmce_pkg::CMD_WRITE1) ? 1 : 0;
      base = bidx * pmce_pkg::BANK_BYTES;
      if (cmd == pmce_pkg::CMD_WRITE0 || cmd == pmce_pkg::CMD_WRITE1) begin
        for (int i = 0; i < pmce_pkg::BANK_BYTES; i++)
          mailbox[base + i] = (i + 2 < pmce_pkg::PACKET_BYTES) ? packet_buf[i + 2] : 8'h00;
        mailbox_len[bidx] = (len > pmce_pkg::BANK_BYTES) ?
                            pmce_pkg::LEN_W'(pmce_pkg::BANK_BYTES) :
                            len[pmce_pkg::LEN_W-1:0];
        mailbox_full[bidx] = 1'b1;
      end else if (cmd == pmce_pkg::CMD_READ0 || cmd == pmce_pkg::CMD_READ1) begin
        if (mailbox_full[bidx] && len <= mailbox_len[bidx]) begin
          for (int i = 0; i < len; i++) reply[i] = mailbox[base + i];
          reply_len = len[pmce_pkg::LEN_W-1:0];
        end else begin
          reply_len = pmce_pkg::LEN_W'(1);
        end
      end else begin
        if (mailbox_full[bidx]) begin
          word = {mailbox[base + 3], mailbox[base + 2], mailbox[base + 1], mailbox[base]} + 32'd1;
          {mailbox[base + 3], mailbox[base + 2], mailbox[base + 1], mailbox[base]} = word;
          for (int i = 0; i < mailbox_len[bidx]; i++) reply[i] = mailbox[base + i];
          reply_len = mailbox_len[bidx];
        end else begin
          reply_len = pmce_pkg::LEN_W'(1);
        end
      end
    end
    n = (reply_len > pmce_pkg::BANK_BYTES) ? pmce_pkg::BANK_BYTES : reply_len;
    for (int k = 0; k < n; k++) begin
      beat.data = reply[k];
      beat.last = (k == n - 1);
      expected_tx.push_back(beat);
    end
  endfunction

  function automatic void take_rx_byte(input logic [7:0] b, input logic end_flag);
    if (rx_count < pmce_pkg::PACKET_BYTES) begin
      packet_buf[rx_count] = b;
      rx_count = rx_count + 1'b1;
    end
    if (end_flag) begin
      execute_packet();
      for (int i = 0; i < pmce_pkg::PACKET_BYTES; i++) packet_buf[i] = 8'h00;
      rx_count = '0;
    end
  endfunction

  function automatic void check_tx_beat(input logic [7:0] data, input logic last);
    reply_beat_t want;
    if (expected_tx.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: tx byte %02h last %0b arrived with no response byte pending",
                 $time, data, last);
      return;
    end
    want = expected_tx.pop_front();
    if (data !== want.data || last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: tx mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                 $time, want.data, want.last, data, last);
    end
  endfunction

  // Both channels are sampled on the rising edge; inputs settle at the falling edge.
  always @(posedge clk) begin
    if (rst) begin
      expected_tx.delete();
      for (int i = 0; i < pmce_pkg::PACKET_BYTES; i++) packet_buf[i] = 8'h00;
      for (int i = 0; i < pmce_pkg::RAM_DEPTH; i++) mailbox[i] = 8'h00;
      mailbox_len[0] = '0;
      mailbox_len[1] = '0;
      mailbox_full[0] = 1'b0;
      mailbox_full[1] = 1'b0;
      reply_len = '0;
      rx_count = '0;
      mismatch_count = 0;
    end else begin
      if (m_tvalid && m_tready) check_tx_beat(m_tdata, m_tlast);
      if (s_tvalid && s_tready) take_rx_byte(s_tdata, s_tlast);
    end
    pending_results = expected_tx.size();
  end

endmodule

// File: tb/packet_mailbox_command_engine_tb.sv
// Testbench top for the packet mailbox command engine: clock, reset, packet stimulus and verdict.
module packet_mailbox_command_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A run of this many cycles with no transaction on either side means the block hung.
  localparam int WATCHDOG_LIMIT  = 2000;
  // The long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BYTES    = 130;
  // Quiet time after the last response byte, to catch any stray output.
  localparam int TAIL_CYCLES     = 60;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // rx_byte [7:0]
  logic       s_tlast  = 1'b0;   // rx_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // tx_byte [7:0]
  logic       m_tlast;           // tx_last
  int         mismatch_count;
  int         pending_results;

  // Idle controls shared by the feeding and draining processes. A maximum of
  // zero gives a stretch with no idling at all on that side.
  int         feed_gap_max      = 8;
  int         drain_gap_max     = 8;
  int         drain_hold_cycles = 0;
  int         bytes_fed         = 0;
  logic [7:0] frame_bytes [$];
  logic [7:0] known_commands [6] = '{pmce_pkg::CMD_WRITE0, pmce_pkg::CMD_READ0,
                                     pmce_pkg::CMD_INC0, pmce_pkg::CMD_WRITE1,
                                     pmce_pkg::CMD_READ1, pmce_pkg::CMD_INC1};

  packet_mailbox_command_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // The checker watches both channels, predicts every response byte and counts
  // mismatches; this module only drives the channels and reports the verdict.
  packet_mailbox_command_engine_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  function automatic int draw_gap(input int max_gap);
    return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
  endfunction

  // Offers one packet byte and returns at the falling edge after the
  // transaction, with tvalid still high so that back-to-back bytes need no
  // second assignment in the same time step. A nonzero gap lowers tvalid
  // first and raises it again only after the gap has passed.
  task automatic send_rx(input logic [7:0] b, input logic end_flag);
    int gap;
    gap = draw_gap(feed_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= end_flag;
    do @(posedge clk); while (!s_tready);
    bytes_fed++;
    @(negedge clk);
  endtask

  // Sends the bytes in frame_bytes as one packet; tlast goes on the final byte.
  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_rx(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Stops offering bytes and waits until every predicted response byte has
  // been taken. The extra falling edge keeps the lowering and the next raise
  // of tvalid in different time steps.
  task automatic drain_all();
    s_tvalid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  // Response side: each byte waits a random number of cycles before tready
  // rises, unless a long hold-off has been requested by the stimulus.
  initial begin : drain_side
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (drain_hold_cycles > 0) begin
        gap = drain_hold_cycles;
        drain_hold_cycles = 0;
      end else begin
        gap = draw_gap(drain_gap_max);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("packet_mailbox_command_engine_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] cmd;
    logic [7:0] len;
    int         data_count;
    int         random_start;
    int         frame_no;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets. The response length register starts at zero and is
    // only changed by Read and Increment, so the order below matters.

    // A Read of bank 0 before any Write answers with a single zero byte.
    frame_bytes = '{pmce_pkg::CMD_READ0, 8'h03};
    send_frame();
    // Increment of unwritten bank 1 in a one-byte packet: the length byte
    // reads as zero, and the answer is again one zero byte.
    frame_bytes = '{pmce_pkg::CMD_INC1};
    send_frame();
    // An unknown command keeps the last response length and sends zeros.
    frame_bytes = '{8'hFF, 8'hFF};
    send_frame();
    // Write the all-ones word to bank 0; the response is one zero byte.
    frame_bytes = '{pmce_pkg::CMD_WRITE0, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // Increment wraps the word around to zero and returns four bytes.
    frame_bytes = '{pmce_pkg::CMD_INC0};
    send_frame();
    // A Read of length zero sets the response length to zero: no bytes.
    frame_bytes = '{pmce_pkg::CMD_READ0, 8'h00};
    send_frame();
    // Unknown command zero with a zero response length: again no bytes.
    frame_bytes = '{8'h00};
    send_frame();
    // Long Write to bank 1: the length clamps to the bank size and the bytes
    // past the packet buffer are dropped while tlast still ends the packet.
    frame_bytes = '{pmce_pkg::CMD_WRITE1, 8'hFF};
    for (int i = 0; i < 22; i++) frame_bytes.push_back(8'(i * 37 + 1));
    send_frame();
    // Read all of bank 1, then one byte more than it holds.
    frame_bytes = '{pmce_pkg::CMD_READ1, 8'(pmce_pkg::BANK_BYTES)};
    send_frame();
    frame_bytes = '{pmce_pkg::CMD_READ1, 8'(pmce_pkg::BANK_BYTES + 1)};
    send_frame();
    // Increment of a full bank returns every stored byte.
    frame_bytes = '{pmce_pkg::CMD_INC1, 8'h00};
    send_frame();
    drain_all();

    // Back pressure: the receiver holds off for a long stretch while full
    // length responses are queued, so the block fills up and stalls its input.
    drain_hold_cycles = HOLD_OFF_CYCLES;
    frame_bytes = '{pmce_pkg::CMD_WRITE0, 8'(pmce_pkg::BANK_BYTES)};
    repeat (pmce_pkg::BANK_BYTES) frame_bytes.push_back(8'($urandom_range(0, 255)));
    send_frame();
    frame_bytes = '{pmce_pkg::CMD_READ0, 8'(pmce_pkg::BANK_BYTES)};
    send_frame();
    send_frame();
    frame_bytes = '{pmce_pkg::CMD_INC0, 8'h00};
    send_frame();
    drain_all();

    // Random packets: mostly known commands with lengths inside the bank, and
    // now and then an unknown command, an oversized length, a short packet or
    // trailing garbage. Idling on each side is switched on and off in stretches.
    random_start = bytes_fed;
    frame_no = 0;
    while (bytes_fed - random_start < RANDOM_BYTES) begin
      frame_no++;
      feed_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (frame_no % 8 == 0) drain_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (frame_no % 20 == 0) drain_all();

      if ($urandom_range(0, 9) == 0) cmd = 8'($urandom_range(0, 255));
      else cmd = known_commands[$urandom_range(0, 5)];
      if ($urandom_range(0, 4) == 0) len = 8'($urandom_range(0, 255));
      else len = 8'($urandom_range(0, pmce_pkg::BANK_BYTES));

      frame_bytes.delete();
      frame_bytes.push_back(cmd);
      if ($urandom_range(0, 11) != 0) begin
        frame_bytes.push_back(len);
        if (cmd == pmce_pkg::CMD_WRITE0 || cmd == pmce_pkg::CMD_WRITE1)
          data_count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24)
                       : ((len > pmce_pkg::BANK_BYTES) ? pmce_pkg::BANK_BYTES : len);
        else
          data_count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        repeat (data_count) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_frame();
    end

    // Let every predicted byte come out, then watch a while for stray output.
    s_tvalid <= 1'b0;
    wait (pending_results == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("packet_mailbox_command_engine_tb: done, clean");
    end else begin
      $display("packet_mailbox_command_engine_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pmce_pkg.sv
rtl/core/pmce_bank_ram.sv
rtl/core/pmce_seq.sv
rtl/core/packet_mailbox_command_engine.sv
tb/packet_mailbox_command_engine_checker.sv
tb/packet_mailbox_command_engine_tb.sv
